// ===== design/sss_pkg.sv =====
package sss_pkg;

	localparam int MAX_SAMPLES_DEF = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// entries in the request queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_MED_A,
		ST_MED_B,
		ST_MED_C,
		ST_DIV
	} sss_state_t;

endpackage

// ===== design/sss_ram.sv =====
module sss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/sss_front.sv =====
module sss_front #(
	parameter int SAMPLE_BITS = sss_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last,
	output logic                   item_valid,
	input  logic                   item_pop,
	output logic [SAMPLE_BITS-1:0] item_sample,
	output logic                   item_last
);

	localparam int PW = $clog2(sss_pkg::QUEUE_DEPTH);
	localparam int FW = $clog2(sss_pkg::QUEUE_DEPTH + 1);

	logic [SAMPLE_BITS-1:0] q_sample_q [sss_pkg::QUEUE_DEPTH];
	logic                   q_last_q   [sss_pkg::QUEUE_DEPTH];
	logic [PW-1:0]          wr_ptr_q, rd_ptr_q;
	logic [FW-1:0]          fill_q;
	logic                   push, pop;

	assign in_stall    = (fill_q == FW'(sss_pkg::QUEUE_DEPTH));
	assign push        = in_valid && !in_stall;
	assign item_valid  = (fill_q != '0);
	assign pop         = item_pop && item_valid;
	assign item_sample = q_sample_q[rd_ptr_q];
	assign item_last   = q_last_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(sss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(sss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_sample_q[wr_ptr_q] <= sample;
			q_last_q[wr_ptr_q]   <= last;
		end
	end

endmodule

// ===== design/sss_div.sv =====
module sss_div #(
	parameter int NW = 26,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q, den_q;
	logic [NW-1:0] acc_q;
	logic [DW:0]   trial;
	logic          ge;

	// restoring division, one quotient bit per cycle, quotient shifts in at the bottom
	assign trial = {rem_q, acc_q[NW-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			acc_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
			acc_q <= {acc_q[NW-2:0], ge};
		end
	end

endmodule

// ===== design/sss_back.sv =====
module sss_back #(
	parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = sss_pkg::SAMPLE_BITS_DEF,
	localparam int CNTW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_pop,
	input  logic signed [SAMPLE_BITS-1:0] item_sample,
	input  logic                          item_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [CNTW-1:0]               count,
	output logic signed [SAMPLE_BITS-1:0] mean,
	output logic signed [SAMPLE_BITS:0]   median_doubled,
	output logic signed [SAMPLE_BITS-1:0] minimum,
	output logic signed [SAMPLE_BITS-1:0] maximum,
	output logic                          overflow
);

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int SUMW = SAMPLE_BITS + CNTW;
	localparam int NW   = SUMW + 1;
	localparam int DW   = CNTW + 1;
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_SAMPLES);

	sss_pkg::sss_state_t state_q, state_d;

	logic [CNTW-1:0]               count_q;
	logic [SUMW-1:0]               sum_q;
	logic                          drop_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q, samp_q, meda_q;
	logic signed [SAMPLE_BITS:0]   med_q;
	logic [AW-1:0]                 pos_q;
	logic                          last_q;

	logic                          out_valid_q, out_drop_q;
	logic [CNTW-1:0]               out_count_q;
	logic signed [SAMPLE_BITS-1:0] out_mean_q, out_min_q, out_max_q;
	logic signed [SAMPLE_BITS:0]   out_med_q;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr, mem_raddr;
	logic signed [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

	logic                          div_start, div_done;
	logic [NW-1:0]                 div_quot;

	logic                          set_full, set_empty, rd_gt, out_free;
	logic [CNTW-1:0]               half, lo_idx;
	logic [SAMPLE_BITS-1:0]        offs_sample, mean_val;

	assign set_full  = (count_q == CNT_MAX);
	assign set_empty = (count_q == '0);
	assign rd_gt     = (mem_rdata > samp_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign half      = count_q >> 1;
	assign lo_idx    = count_q[0] ? half : half - CNTW'(1);

	// sum of offset-binary samples keeps the numerator non-negative
	assign offs_sample = {~item_sample[SAMPLE_BITS-1], item_sample[SAMPLE_BITS-2:0]};
	assign mean_val    = {~div_quot[SAMPLE_BITS-1], div_quot[SAMPLE_BITS-2:0]};

	sss_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sss_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({sum_q, 1'b0} + NW'(count_q)),
		.den    ({count_q, 1'b0}),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sss_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (set_full || set_empty) begin
						state_d = item_last ? sss_pkg::ST_MED_A : sss_pkg::ST_IDLE;
					end else begin
						state_d = sss_pkg::ST_SHIFT;
					end
				end
			end
			sss_pkg::ST_SHIFT: begin
				if (rd_gt) begin
					state_d = (pos_q == AW'(1)) ? sss_pkg::ST_PLACE : sss_pkg::ST_SHIFT;
				end else begin
					state_d = last_q ? sss_pkg::ST_MED_A : sss_pkg::ST_IDLE;
				end
			end
			sss_pkg::ST_PLACE: state_d = last_q ? sss_pkg::ST_MED_A : sss_pkg::ST_IDLE;
			sss_pkg::ST_MED_A: state_d = sss_pkg::ST_MED_B;
			sss_pkg::ST_MED_B: state_d = sss_pkg::ST_MED_C;
			sss_pkg::ST_MED_C: state_d = sss_pkg::ST_DIV;
			sss_pkg::ST_DIV: begin
				if (div_done && out_free) begin
					state_d = sss_pkg::ST_IDLE;
				end
			end
			default: state_d = sss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_pop  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = samp_q;
		mem_raddr = pos_q - AW'(2);
		div_start = 1'b0;
		unique case (state_q)
			sss_pkg::ST_IDLE: begin
				item_pop  = item_valid;
				mem_we    = item_valid && set_empty;
				mem_waddr = '0;
				mem_wdata = item_sample;
				mem_raddr = AW'(count_q - CNTW'(1));
			end
			sss_pkg::ST_SHIFT: begin
				// walk down the sorted run, moving larger entries up by one
				mem_we    = 1'b1;
				mem_wdata = rd_gt ? mem_rdata : samp_q;
			end
			sss_pkg::ST_PLACE: mem_we = 1'b1;
			sss_pkg::ST_MED_A: begin
				mem_raddr = AW'(lo_idx);
				div_start = 1'b1;
			end
			sss_pkg::ST_MED_B: mem_raddr = AW'(half);
			sss_pkg::ST_MED_C: mem_raddr = AW'(half);
			sss_pkg::ST_DIV:   mem_raddr = AW'(half);
			default: mem_raddr = AW'(half);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sss_pkg::ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sss_pkg::ST_IDLE && item_valid) begin
				if (set_full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CNTW'(1);
					sum_q   <= sum_q + SUMW'(offs_sample);
				end
			end
			if (state_q == sss_pkg::ST_DIV && div_done && out_free) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				sum_q       <= '0;
				drop_q      <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sss_pkg::ST_IDLE && item_valid) begin
			samp_q <= item_sample;
			last_q <= item_last;
			pos_q  <= AW'(count_q);
			if (!set_full) begin
				if (set_empty || item_sample < min_q) begin
					min_q <= item_sample;
				end
				if (set_empty || item_sample > max_q) begin
					max_q <= item_sample;
				end
			end
		end
		if (state_q == sss_pkg::ST_SHIFT && rd_gt) begin
			pos_q <= pos_q - AW'(1);
		end
		if (state_q == sss_pkg::ST_MED_B) begin
			meda_q <= mem_rdata;
		end
		// held here until the output register is free
		if (state_q == sss_pkg::ST_MED_C) begin
			med_q <= {meda_q[SAMPLE_BITS-1], meda_q} + {mem_rdata[SAMPLE_BITS-1], mem_rdata};
		end
		if (state_q == sss_pkg::ST_DIV && div_done && out_free) begin
			out_count_q <= count_q;
			out_mean_q  <= mean_val;
			out_med_q   <= med_q;
			out_min_q   <= min_q;
			out_max_q   <= max_q;
			out_drop_q  <= drop_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign count          = out_count_q;
	assign mean           = out_mean_q;
	assign median_doubled = out_med_q;
	assign minimum        = out_min_q;
	assign maximum        = out_max_q;
	assign overflow       = out_drop_q;

endmodule

// ===== design/sample_set_statistics.sv =====
// Statistics over a set of signed samples, one sample per input request.
// Input channel: sample, last, with in_valid / in_stall. A request carrying
// last closes the set; that set then yields one request on the output channel:
// count, mean (rounded half up), median_doubled, minimum, maximum, overflow.
// Samples past MAX_SAMPLES in a set are dropped and overflow is set.
// A four-entry queue takes requests while the back end sorts; in_stall rises
// only when that queue is full.
// Each kept sample is insertion-sorted into a single-port-write RAM: it is popped,
// each larger entry already stored is moved up by one and the sample is placed; the
// first sample of a set is written as it is popped and a dropped sample is only popped.
// Closing a set then runs the restoring divider over the NW-bit numerator,
// NW = SAMPLE_BITS + clog2(MAX_SAMPLES+1) + 1; the median reads overlap the divider
// and the output register is loaded once the divider is done and the register is free.
// The output register holds a result while out_stall is high; the next set
// keeps sorting meanwhile and waits only when its own result is ready.
// Reset clears the queue, the set counters and the output valid; the sample
// RAM is not cleared, since only entries already written are ever read.
module sample_set_statistics #(
	parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = sss_pkg::SAMPLE_BITS_DEF,
	localparam int CNTW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [CNTW-1:0]               count,
	output logic signed [SAMPLE_BITS-1:0] mean,
	output logic signed [SAMPLE_BITS:0]   median_doubled,
	output logic signed [SAMPLE_BITS-1:0] minimum,
	output logic signed [SAMPLE_BITS-1:0] maximum,
	output logic                          overflow
);

	logic                          item_valid, item_pop, item_last;
	logic signed [SAMPLE_BITS-1:0] item_sample;

	sss_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.last        (last),
		.item_valid  (item_valid),
		.item_pop    (item_pop),
		.item_sample (item_sample),
		.item_last   (item_last)
	);

	sss_back #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_pop       (item_pop),
		.item_sample    (item_sample),
		.item_last      (item_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.count          (count),
		.mean           (mean),
		.median_doubled (median_doubled),
		.minimum        (minimum),
		.maximum        (maximum),
		.overflow       (overflow)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count != '0) && (count <= CNTW'(MAX_SAMPLES)))
		else $error("result count out of range");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (minimum <= maximum))
		else $error("minimum above maximum");

	a_mean_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mean >= minimum) && (mean <= maximum))
		else $error("mean outside sample range");

	a_median_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (median_doubled >= $signed({minimum, 1'b0}))
			&& (median_doubled <= $signed({maximum, 1'b0})))
		else $error("median outside sample range");

endmodule

// ===== dv/tb_sample_set_statistics.sv =====
module tb_sample_set_statistics;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = sss_pkg::SAMPLE_BITS_DEF;
	localparam int DEPTH = sss_pkg::MAX_SAMPLES_DEF;
	localparam int CW = $clog2(DEPTH + 1);
	// cycles with no request moving on either channel before giving up
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef logic signed [SB-1:0] sample_t;

	localparam sample_t SMIN = {1'b1, {(SB-1){1'b0}}};
	localparam sample_t SMAX = {1'b0, {(SB-1){1'b1}}};

	typedef struct {
		logic [CW-1:0]        count;
		logic signed [SB-1:0] mean;
		logic signed [SB:0]   median_doubled;
		logic signed [SB-1:0] minimum;
		logic signed [SB-1:0] maximum;
		logic                 overflow;
	} set_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	sample_t              sample;
	logic                 last;
	logic                 out_valid;
	logic                 out_stall;
	logic [CW-1:0]        count;
	logic signed [SB-1:0] mean;
	logic signed [SB:0]   median_doubled;
	logic signed [SB-1:0] minimum;
	logic signed [SB-1:0] maximum;
	logic                 overflow;

	// predicted contents of the open set
	sample_t     set_sorted[$];
	longint      set_sum = 0;
	logic        set_overflow = 1'b0;
	set_result_t pending_results[$];

	int err_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_off_len = 0;
	int idle_run = 0;

	sample_set_statistics uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.last           (last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.count          (count),
		.mean           (mean),
		.median_doubled (median_doubled),
		.minimum        (minimum),
		.maximum        (maximum),
		.overflow       (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// add one accepted sample to the set; closing it queues the expected stats
	function automatic void add_to_set(input sample_t s, input logic closes);
		int pos;
		longint n;
		longint num;
		longint den;
		longint q;
		longint m;
		set_result_t r;
		if (set_sorted.size() < DEPTH) begin
			pos = set_sorted.size();
			while (pos > 0 && set_sorted[pos-1] > s)
				pos--;
			set_sorted.insert(pos, s);
			set_sum += s;
		end else
			set_overflow = 1'b1;
		if (!closes)
			return;
		n = set_sorted.size();
		// mean rounded half up: floor((2*sum + n) / (2*n))
		num = 2 * set_sum + n;
		den = 2 * n;
		q = num / den;
		if (num % den != 0 && num < 0)
			q--;
		if (n % 2 == 0)
			m = longint'(set_sorted[n/2-1]) + longint'(set_sorted[n/2]);
		else
			m = 2 * longint'(set_sorted[n/2]);
		r.count = n[CW-1:0];
		r.mean = q[SB-1:0];
		r.median_doubled = m[SB:0];
		r.minimum = set_sorted[0];
		r.maximum = set_sorted[n-1];
		r.overflow = set_overflow;
		pending_results = {pending_results, r};
		set_sorted.delete();
		set_sum = 0;
		set_overflow = 1'b0;
	endfunction

	function automatic sample_t rand_sample(input int mode);
		int pick;
		case (mode)
			0: begin
				return sample_t'($urandom);
			end
			1: begin
				// narrow range, lots of duplicates
				return sample_t'($urandom_range(6)) - sample_t'(3);
			end
			default: begin
				pick = $urandom_range(3);
				if (pick == 0)
					return SMIN;
				else if (pick == 1)
					return SMAX;
				else if (pick == 2)
					return sample_t'(0) - sample_t'($urandom_range(1));
				else
					return sample_t'($urandom);
			end
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_sample(input sample_t s, input logic closes);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		last <= closes;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		add_to_set(s, closes);
	endtask

	task automatic send_set(input sample_t vals[$]);
		foreach (vals[i])
			send_sample(vals[i], i == vals.size() - 1);
	endtask

	task automatic test_directed();
		sample_t v[$];
		send_idle_pct = 0;
		stall_pct = 0;
		v = {SMIN};
		send_set(v);
		v = {SMAX};
		send_set(v);
		v = {SMAX, SMAX};
		send_set(v);
		v = {SMIN, SMIN};
		send_set(v);
		// half steps: 1.5 -> 2, -1.5 -> -1, -0.5 -> 0
		v = {sample_t'(1), sample_t'(2)};
		send_set(v);
		v = {sample_t'(-1), sample_t'(-2)};
		send_set(v);
		v = {sample_t'(0), sample_t'(-1)};
		send_set(v);
		v = {sample_t'(16'h5555), SMAX, sample_t'(16'hAAAA), SMIN};
		send_set(v);
		v = {sample_t'(40), sample_t'(30), sample_t'(20), sample_t'(10), sample_t'(-10)};
		send_set(v);
		v = {sample_t'(7), sample_t'(7), sample_t'(7)};
		send_set(v);
	endtask

	task automatic test_full_store();
		sample_t v[$];
		send_idle_pct = 0;
		stall_pct = 14;
		// exactly full, nothing dropped
		repeat (DEPTH)
			v = {v, rand_sample(0)};
		send_set(v);
		// descending: every insert shifts the whole store, the closing request is dropped
		v.delete();
		for (int i = 0; i <= DEPTH; i++)
			v = {v, SMAX - sample_t'(i * 100)};
		send_set(v);
		// several dropped, then a set that has to start clean
		v.delete();
		repeat (DEPTH + 5)
			v = {v, rand_sample(2)};
		send_set(v);
		v = {SMIN, sample_t'(5)};
		send_set(v);
	endtask

	task automatic test_random_sets();
		int idle_mix[4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{14, 14}};
		sample_t v[$];
		int sent;
		int size;
		int r;
		int mode;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_mix[ph][0];
			stall_pct = idle_mix[ph][1];
			sent = 0;
			while (sent < 200) begin
				r = $urandom_range(99);
				if (r < 85)
					size = $urandom_range(8, 1);
				else if (r < 99)
					size = $urandom_range(32, 9);
				else
					size = $urandom_range(300, 100);
				mode = $urandom_range(2);
				v.delete();
				repeat (size)
					v = {v, rand_sample(mode)};
				send_set(v);
				sent += size;
			end
		end
	endtask

	// receiver holds off while the sender keeps going, so the input queue fills
	task automatic test_backpressure();
		sample_t v[$];
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_len = HOLD_OFF_CYCLES;
		repeat (12) begin
			v.delete();
			repeat ($urandom_range(4, 1))
				v = {v, rand_sample(0)};
			send_set(v);
		end
	endtask

	initial begin : receiver
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				n = hold_off_len;
				hold_off_len = 0;
				out_stall <= 1'b1;
				repeat (n)
					@(posedge clk);
			end else
				out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		set_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result request with no set closed: count %0d mean %0d", count, mean);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, count);
					err_count++;
				end
				if (mean !== want.mean) begin
					$error("mean: expected %0d, got %0d", want.mean, mean);
					err_count++;
				end
				if (median_doubled !== want.median_doubled) begin
					$error("median_doubled: expected %0d, got %0d",
						want.median_doubled, median_doubled);
					err_count++;
				end
				if (minimum !== want.minimum) begin
					$error("minimum: expected %0d, got %0d", want.minimum, minimum);
					err_count++;
				end
				if (maximum !== want.maximum) begin
					$error("maximum: expected %0d, got %0d", want.maximum, maximum);
					err_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, overflow);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_run <= 0;
		else if (idle_run >= STALL_LIMIT) begin
			$display("[sample_set_statistics] ERROR");
			$finish;
		end else
			idle_run <= idle_run + 1;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		last = 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_random_sets();
		test_backpressure();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (err_count == 0)
			$display("[sample_set_statistics] OK");
		else
			$display("[sample_set_statistics] ERROR");
		$finish;
	end

endmodule
